FILE: rtl/bst_pkg.sv
// bst_pkg: shared types and constants for the bounded set table
// no dependencies
`timescale 1ns / 1ps

package bst_pkg;

  localparam int VALUE_W  = 32;
  localparam int ACTION_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

FILE: rtl/bst_channels.sv
// bst channel interfaces: request, response and capacity write channels
// depends on bst_pkg
`timescale 1ns / 1ps

interface bst_req_if;
  logic                                valid;
  logic                                ready;
  logic [bst_pkg::ACTION_W-1:0]        action;
  logic signed [bst_pkg::VALUE_W-1:0]  value;

  modport source(output valid, action, value, input ready);
  modport sink(input valid, action, value, output ready);
endinterface

interface bst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [bst_pkg::COUNT_W-1:0]   count;

  modport source(output valid, ok, count, input ready);
  modport sink(input valid, ok, count, output ready);
endinterface

interface bst_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bst_pkg::CFG_W-1:0]   capacity_in_use;

  modport source(output valid, capacity_in_use, input ready);
  modport sink(input valid, capacity_in_use, output ready);
endinterface

FILE: rtl/bst_store.sv
// bst_store: entry memory, one write and one registered read per cycle
// depends on bst_pkg
`timescale 1ns / 1ps

module bst_store #(
  parameter int CAPACITY = 16,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [bst_pkg::VALUE_W-1:0]   wr_data,
  input  logic [AW-1:0]                 rd_addr,
  output logic [bst_pkg::VALUE_W-1:0]   rd_data
);
  import bst_pkg::*;

  logic [VALUE_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/bst_ctrl.sv
// bst_ctrl: sequencer with the shared equality compare, scan and shift-down
// depends on bst_pkg, bst_channels and the bst_store read/write timing
`timescale 1ns / 1ps

module bst_ctrl #(
  parameter int CAPACITY = 16,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  bst_req_if.sink                       req,
  input  logic [bst_pkg::CFG_W-1:0]     cap,
  output logic [AW-1:0]                 rd_addr,
  input  logic [bst_pkg::VALUE_W-1:0]   rd_data,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output logic [bst_pkg::VALUE_W-1:0]   wr_data,
  output bst_pkg::res_t                 res,
  output logic                          res_valid,
  input  logic                          res_ready
);
  import bst_pkg::*;

  localparam int LW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_FETCH    = 6'b000010,
    S_CHECK    = 6'b000100,
    S_RESOLVE  = 6'b001000,
    S_SHIFT_RD = 6'b010000,
    S_SHIFT_WR = 6'b100000
  } state_t;

  state_t              state, state_next;
  logic                finish, finish_next;
  action_t             action;
  logic [VALUE_W-1:0]  value;
  logic [CW-1:0]       idx, idx_next;
  logic [CW-1:0]       held_count, held_count_next;
  logic                found, found_next;
  logic                ok, ok_next;
  logic [CW-1:0]       idx_inc;
  logic [LW-1:0]       cap_ext, limit, cnt_ext;
  logic                has_room;

  assign idx_inc  = idx + CW'(1);
  assign cap_ext  = LW'(cap);
  assign cnt_ext  = LW'(held_count);
  assign limit    = (cap_ext > CAP_L) ? CAP_L : cap_ext;
  assign has_room = cnt_ext < limit;

  assign req.ready = (state == S_IDLE) && !finish;
  assign res_valid = finish;
  assign res.ok    = ok;
  assign res.count = COUNT_W'(held_count);

  assign rd_addr = (state == S_SHIFT_RD) ? idx_inc[AW-1:0] : idx[AW-1:0];

  always_comb begin
    state_next      = state;
    finish_next     = finish;
    idx_next        = idx;
    held_count_next = held_count;
    found_next      = found;
    ok_next         = ok;
    wr_en           = 1'b0;
    wr_addr         = idx[AW-1:0];
    wr_data         = rd_data;
    case (state)
      S_IDLE: begin
        if (finish) begin
          if (res_ready) begin
            finish_next = 1'b0;
          end
        end else if (req.valid) begin
          idx_next   = '0;
          found_next = 1'b0;
          ok_next    = 1'b0;
          if (held_count != '0 && action_t'(req.action) != ACT_NONE) begin
            state_next = S_FETCH;
          end else begin
            state_next = S_RESOLVE;
          end
        end
      end
      S_FETCH: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (rd_data == value) begin
          found_next = 1'b1;
          state_next = S_RESOLVE;
        end else if (idx_inc == held_count) begin
          state_next = S_RESOLVE;
        end else begin
          idx_next   = idx_inc;
          state_next = S_FETCH;
        end
      end
      S_RESOLVE: begin
        state_next  = S_IDLE;
        finish_next = 1'b1;
        case (action)
          ACT_LOOKUP: begin
            ok_next = found;
          end
          ACT_INSERT: begin
            if (!found && has_room) begin
              wr_en           = 1'b1;
              wr_addr         = held_count[AW-1:0];
              wr_data         = value;
              held_count_next = held_count + CW'(1);
              ok_next         = 1'b1;
            end
          end
          ACT_REMOVE: begin
            if (found) begin
              ok_next = 1'b1;
              if (idx_inc < held_count) begin
                state_next  = S_SHIFT_RD;
                finish_next = 1'b0;
              end else begin
                held_count_next = held_count - CW'(1);
              end
            end
          end
          default: begin
            ok_next = 1'b0;
          end
        endcase
      end
      S_SHIFT_RD: begin
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        wr_en    = 1'b1;
        idx_next = idx_inc;
        if (idx_inc + CW'(1) < held_count) begin
          state_next = S_SHIFT_RD;
        end else begin
          held_count_next = held_count - CW'(1);
          state_next      = S_IDLE;
          finish_next     = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      finish     <= 1'b0;
      held_count <= '0;
    end else begin
      state      <= state_next;
      finish     <= finish_next;
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    found <= found_next;
    ok    <= ok_next;
    if (req.valid && req.ready) begin
      action <= action_t'(req.action);
      value  <= req.value;
    end
  end

endmodule

FILE: rtl/bounded_set_table_core.sv
// bounded_set_table_core: top level, capacity register, response register
// depends on bst_pkg, bst_channels, bst_store and bst_ctrl
//
//  channel  dir  fields                  meaning
//  req      in   action, value           lookup / insert / remove of one value
//  rsp      out  ok, count               outcome and element count after it
//  cfg      in   capacity_in_use         element limit, saturates at CAPACITY
//
// a request other than ACT_NONE scans the entries one at a time in the single
// compare unit, stopping at a match or after the last one, then resolves; a
// remove then shifts each later entry down through the store's two ports
// reset empties the set and sets the limit to 16; no clearing pass is needed
// req.ready is low while a request is in work or its response cannot move on
// the response register holds one result so the sequencer can take the next request while rsp is stalled
`timescale 1ns / 1ps

module bounded_set_table_core #(
  parameter int CAPACITY = 16
) (
  input  logic     clk,
  input  logic     rst,
  bst_req_if.sink  req,
  bst_rsp_if.source rsp,
  bst_cfg_if.sink  cfg
);
  import bst_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CFG_W-1:0]    cap;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [VALUE_W-1:0]  rd_data, wr_data;
  logic                wr_en;
  res_t                res;
  logic                res_valid, res_ready;
  logic                rsp_valid;
  res_t                rsp_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg.valid) begin
      cap <= cfg.capacity_in_use;
    end
  end

  bst_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bst_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cap       (cap),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  // response register
  assign res_ready = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp_data <= res;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.ok    = rsp_data.ok;
  assign rsp.count = rsp_data.count;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("accepted a request while one was in work");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> rsp.valid)
    else $error("handed-off result missing from response register");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (CAPACITY > 31) || (int'(rsp.count) <= CAPACITY))
    else $error("count above capacity");

endmodule

FILE: test/tb_bounded_set_table_core.sv
// testbench for bounded_set_table_core: directed and random lookup, insert, remove and none requests
// checked against an in-bench model of the packed set; depends on bst_pkg, bst_channels and bounded_set_table_core
`timescale 1ns / 1ps

module tb_bounded_set_table_core;
  import bst_pkg::*;

  localparam int SET_CAP    = 16;
  localparam int POOL_N     = 20;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;

  bst_req_if req_ch();
  bst_rsp_if rsp_ch();
  bst_cfg_if cfg_ch();

  bounded_set_table_core #(.CAPACITY(SET_CAP)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // model of the set
  logic [VALUE_W-1:0] set_vals [SET_CAP];
  int                 held_n = 0;
  logic [CFG_W-1:0]   cap_reg = CAP_RESET;

  res_t        expected_q [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          no_idle = 0;
  logic [31:0] value_pool [POOL_N];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic res_t apply_set_action(action_t act, logic [VALUE_W-1:0] v);
    int   pos;
    int   lim;
    logic found;
    res_t r;
    pos = held_n;
    for (int i = held_n - 1; i >= 0; i--) begin
      if (set_vals[i] == v) pos = i;
    end
    found = pos < held_n;
    lim = (cap_reg > SET_CAP) ? SET_CAP : int'(cap_reg);
    r.ok = 1'b0;
    case (act)
      ACT_LOOKUP: begin
        r.ok = found;
      end
      ACT_INSERT: begin
        if (!found && held_n < lim) begin
          set_vals[held_n] = v;
          held_n++;
          r.ok = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (found) begin
          for (int j = pos; j + 1 < held_n; j++) set_vals[j] = set_vals[j + 1];
          held_n--;
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.count = held_n[COUNT_W-1:0];
    return r;
  endfunction

  task automatic send_request(action_t act, logic [VALUE_W-1:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid  = 1'b1;
    req_ch.action = act;
    req_ch.value  = v;
    do @(posedge clk); while (!req_ch.ready);
    expected_q.push_back(apply_set_action(act, v));
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] c);
    pause_until_drained();
    @(negedge clk);
    cfg_ch.valid           = 1'b1;
    cfg_ch.capacity_in_use = c;
    do @(posedge clk); while (!cfg_ch.ready);
    cap_reg = c;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // response side: random stall before each response unless no_idle is set, then compare
  initial begin
    int   stall;
    res_t want;
    rsp_ch.ready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      @(negedge clk);
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: ok=%0b count=%0d", rsp_ch.ok, rsp_ch.count);
      end else begin
        want = expected_q.pop_front();
        if (rsp_ch.ok !== want.ok || rsp_ch.count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected ok=%0b count=%0d, got ok=%0b count=%0d",
                     want.ok, want.count, rsp_ch.ok, rsp_ch.count);
        end
      end
    end
  end

  task automatic test_directed_ops();
    send_request(ACT_LOOKUP, 32'h0000_0000);
    send_request(ACT_INSERT, 32'h8000_0000);
    send_request(ACT_INSERT, 32'h7fff_ffff);
    send_request(ACT_INSERT, 32'h0000_0000);
    send_request(ACT_INSERT, 32'hffff_ffff);
    send_request(ACT_INSERT, 32'h7fff_ffff);
    send_request(ACT_LOOKUP, 32'hffff_ffff);
    send_request(ACT_NONE,   32'h1234_5678);
    send_request(ACT_REMOVE, 32'h8000_0000);
    send_request(ACT_REMOVE, 32'h8000_0000);
    send_request(ACT_LOOKUP, 32'h8000_0000);
    send_request(ACT_LOOKUP, 32'h0000_0000);
    send_request(ACT_REMOVE, 32'hffff_ffff);
  endtask

  task automatic test_capacity_edges();
    // limit below the current count
    write_capacity(5'd1);
    send_request(ACT_INSERT, 32'h0000_0005);
    send_request(ACT_LOOKUP, 32'h0000_0000);
    send_request(ACT_REMOVE, 32'h7fff_ffff);
    send_request(ACT_INSERT, 32'h0000_0007);
    send_request(ACT_INSERT, 32'h0000_0000);
    // zero limit
    write_capacity(5'd0);
    send_request(ACT_REMOVE, 32'h0000_0000);
    send_request(ACT_INSERT, 32'h0000_0009);
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0]   caps [9];
    int                 ins_pct;
    int                 r;
    action_t            act;
    logic [VALUE_W-1:0] v;
    caps = '{5'd31, 5'd16, 5'd1, 5'd0, 5'd17, 5'd5, 5'd16, 5'd2, 5'd0};
    caps[8] = CFG_W'($urandom_range(0, 31));
    for (int p = 0; p < 9; p++) begin
      write_capacity(caps[p]);
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      for (int i = 2; i < POOL_N; i++) value_pool[i] = $urandom;
      no_idle = (p == 6);
      ins_pct = (p % 2 == 0) ? 55 : 30;
      for (int k = 0; k < 50; k++) begin
        if (p == 4 && k == 25) pause_until_drained();
        r = $urandom_range(0, 99);
        if (r < ins_pct) act = ACT_INSERT;
        else if (r < ins_pct + (95 - ins_pct) / 2) act = ACT_LOOKUP;
        else if (r < 95) act = ACT_REMOVE;
        else act = ACT_NONE;
        if ($urandom_range(0, 9) == 0) v = $urandom;
        else v = value_pool[$urandom_range(0, POOL_N - 1)];
        send_request(act, v);
      end
    end
    no_idle = 0;
  endtask

  initial begin
    clk                    = 1'b0;
    rst                    = 1'b1;
    req_ch.valid           = 1'b0;
    req_ch.action          = ACT_LOOKUP;
    req_ch.value           = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.capacity_in_use = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_ops();
    test_capacity_edges();
    test_random_traffic();

    pause_until_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/bst_pkg.sv
rtl/bst_channels.sv
rtl/bst_store.sv
rtl/bst_ctrl.sv
rtl/bounded_set_table_core.sv
test/tb_bounded_set_table_core.sv
